/* hw/rtl/nfcs_pkg.sv */
// Shared constants and control structs for the nearest free cell search block.
// Used by the ring generator, the top level and the checker.
`default_nettype none

package nfcs_pkg;

    localparam int MAX_DIM_DEF = 64;

    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;
    localparam int COORD_IN_W  = 11;
    localparam int OUT_COORD_W = 6;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] GRID_DIM_RESET = 7'd64;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic start;
        logic halt;
    } gen_ctrl_t;

    typedef struct packed {
        logic cand_valid;
        logic exhausted;
    } gen_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/nfcs_map_mem.sv */
// One-bit blocked map storage: one write port, one read port, registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module nfcs_map_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic               rd_data
);

    logic mem [DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/nfcs_ring_gen.sv */
// Candidate cell sequencer: the preferred cell, then the perimeter of each ring in scan order.
// Emits at most one in-grid cell per cycle. Depends on nfcs_pkg.
`default_nettype none

module nfcs_ring_gen #(
    parameter int MAX_DIM = nfcs_pkg::MAX_DIM_DEF,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int DW      = $clog2(MAX_DIM + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nfcs_pkg::gen_ctrl_t ctrl,
    input  wire logic [CW-1:0]      pref_col,
    input  wire logic [CW-1:0]      pref_row,
    input  wire logic [DW-1:0]      dim_w,
    input  wire logic [DW-1:0]      dim_h,
    output nfcs_pkg::gen_stat_t     stat,
    output logic [CW-1:0]           cand_col,
    output logic [CW-1:0]           cand_row
);

    localparam int SW = CW + 2;
    localparam int RW = $clog2(MAX_DIM + 2);

    typedef enum logic [5:0] {
        G_IDLE  = 6'b000001,
        G_PREF  = 6'b000010,
        G_RING  = 6'b000100,
        G_EDGE  = 6'b001000,
        G_LEFT  = 6'b010000,
        G_RIGHT = 6'b100000
    } gen_state_t;

    gen_state_t state_reg, state_next;
    logic [RW-1:0] rad_reg, rad_next;
    logic signed [SW-1:0] row_reg, row_next;
    logic signed [SW-1:0] col_reg, col_next;

    logic signed [SW-1:0] pc_s, pr_s, rad_s, wm1, hm1;
    logic signed [SW-1:0] c0, c1, r0, r1;
    logic signed [SW-1:0] col_lo, col_hi, row_first, row_last, row_sel;
    logic signed [SW-1:0] cand_c_s, cand_r_s;
    logic [DW-1:0] max_dim;
    logic [RW-1:0] max_rad;
    logic sel_edge, last_row, row_done, enter_row;

    assign pc_s  = $signed({{(SW-CW){1'b0}}, pref_col});
    assign pr_s  = $signed({{(SW-CW){1'b0}}, pref_row});
    assign rad_s = $signed({{(SW-RW){1'b0}}, rad_reg});
    assign wm1   = $signed({{(SW-DW){1'b0}}, dim_w}) - SW'(1);
    assign hm1   = $signed({{(SW-DW){1'b0}}, dim_h}) - SW'(1);

    assign c0 = pc_s - rad_s;
    assign c1 = pc_s + rad_s;
    assign r0 = pr_s - rad_s;
    assign r1 = pr_s + rad_s;

    assign col_lo    = (c0 < 0) ? '0 : c0;
    assign col_hi    = (c1 > wm1) ? wm1 : c1;
    assign row_first = (r0 < 0) ? '0 : r0;
    assign row_last  = (r1 > hm1) ? hm1 : r1;
    assign row_sel   = (state_reg == G_RING) ? row_first : row_reg + SW'(1);
    assign sel_edge  = (row_sel == r0) || (row_sel == r1);
    assign last_row  = (row_reg == row_last);

    assign max_dim = (dim_w > dim_h) ? dim_w : dim_h;
    assign max_rad = RW'(max_dim);

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        cand_c_s   = col_reg;
        cand_r_s   = row_reg;
        stat       = '0;
        row_done   = 1'b0;
        enter_row  = 1'b0;

        case (state_reg)
            G_IDLE:
            begin
            end
            G_PREF:
            begin
                stat.cand_valid = 1'b1;
                cand_c_s        = pc_s;
                cand_r_s        = pr_s;
                rad_next        = RW'(1);
                state_next      = G_RING;
            end
            G_RING:
            begin
                if (rad_reg > max_rad)
                begin
                    stat.exhausted = 1'b1;
                    state_next     = G_IDLE;
                end
                else
                begin
                    enter_row = 1'b1;
                end
            end
            G_EDGE:
            begin
                stat.cand_valid = 1'b1;
                if (col_reg == col_hi)
                begin
                    row_done = 1'b1;
                end
                else
                begin
                    col_next = col_reg + SW'(1);
                end
            end
            G_LEFT:
            begin
                stat.cand_valid = (c0 >= 0);
                cand_c_s        = c0;
                state_next      = G_RIGHT;
            end
            G_RIGHT:
            begin
                stat.cand_valid = (c1 <= wm1);
                cand_c_s        = c1;
                row_done        = 1'b1;
            end
            default:
            begin
                state_next = G_IDLE;
            end
        endcase

        if (row_done)
        begin
            if (last_row)
            begin
                rad_next   = rad_reg + RW'(1);
                state_next = G_RING;
            end
            else
            begin
                enter_row = 1'b1;
            end
        end

        if (enter_row)
        begin
            row_next = row_sel;
            if (sel_edge)
            begin
                col_next   = col_lo;
                state_next = G_EDGE;
            end
            else
            begin
                state_next = G_LEFT;
            end
        end

        if (ctrl.halt)
        begin
            stat.cand_valid = 1'b0;
            state_next      = G_IDLE;
        end
        if (ctrl.start)
        begin
            state_next = G_PREF;
        end
    end

    assign cand_col = cand_c_s[CW-1:0];
    assign cand_row = cand_r_s[CW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= rad_next;
        row_reg <= row_next;
        col_reg <= col_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/nearest_free_cell_search.sv */
// Top level of the nearest free cell search: control, clamping, map check and result register.
// Instantiates nfcs_map_mem and nfcs_ring_gen; depends on nfcs_pkg.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  config   | cfg_write                  | cfg_index, cfg_data
//  input    | in_valid / in_stall        | command, target_col, target_row, blocked_bit
//  output   | out_valid / out_stall      | found_col, found_row, found_free
//
// After reset the map is cleared one cell per cycle, all MAX_DIM*MAX_DIM cells, with in_stall high.
// A write transfer returns no result.
// A query reads the map at one candidate cell at a time through the single read port: the
// preferred cell first, then the perimeter of each ring. A result waits in the output register
// while the next transfer is taken, and a later result holds in_stall high until that register
// drains.
`default_nettype none

module nearest_free_cell_search #(
    parameter int MAX_DIM = nfcs_pkg::MAX_DIM_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire logic [nfcs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [nfcs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               command,
    input  wire logic signed [nfcs_pkg::COORD_IN_W-1:0] target_col,
    input  wire logic signed [nfcs_pkg::COORD_IN_W-1:0] target_row,
    input  wire logic                               blocked_bit,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [nfcs_pkg::OUT_COORD_W-1:0]        found_col,
    output logic [nfcs_pkg::OUT_COORD_W-1:0]        found_row,
    output logic                                    found_free
);

    localparam int CW    = $clog2(MAX_DIM);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = (DW > nfcs_pkg::CFG_DATA_W) ? DW : nfcs_pkg::CFG_DATA_W;
    localparam int LW    = (DW > nfcs_pkg::COORD_IN_W - 1) ? DW : nfcs_pkg::COORD_IN_W - 1;
    localparam int XW    = (CW > nfcs_pkg::OUT_COORD_W) ? CW : nfcs_pkg::OUT_COORD_W;
    localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);
    localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } ctl_state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] c, input logic [CW-1:0] r);
        return AW'(r) * DIM_A + AW'(c);
    endfunction

    function automatic logic [DW-1:0] eff_dim(input logic [nfcs_pkg::CFG_DATA_W-1:0] v);
        logic [EW-1:0] v_ext;
        v_ext = EW'(v);
        if (v_ext == '0)
        begin
            return DW'(1);
        end
        else if (v_ext > EW'(MAX_DIM))
        begin
            return DW'(MAX_DIM);
        end
        return DW'(v_ext);
    endfunction

    function automatic logic [CW-1:0] clamp_coord(
        input logic signed [nfcs_pkg::COORD_IN_W-1:0] t,
        input logic [DW-1:0] dim
    );
        logic [LW-1:0] mag;
        logic [LW-1:0] dim_ext;
        mag     = LW'(t[nfcs_pkg::COORD_IN_W-2:0]);
        dim_ext = LW'(dim);
        if (t[nfcs_pkg::COORD_IN_W-1])
        begin
            return '0;
        end
        else if (mag >= dim_ext)
        begin
            return CW'(dim_ext - LW'(1));
        end
        return CW'(mag);
    endfunction

    ctl_state_t state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [nfcs_pkg::CFG_DATA_W-1:0] grid_width_reg, grid_height_reg;
    logic [CW-1:0] pc_reg, pc_next, pr_reg, pr_next;
    logic chk_valid_reg;
    logic [CW-1:0] chk_col_reg, chk_row_reg;
    logic [CW-1:0] res_col_reg, res_col_next, res_row_reg, res_row_next;
    logic res_free_reg, res_free_next;
    logic out_valid_reg, out_valid_next;
    logic [XW-1:0] out_col_reg, out_col_next, out_row_reg, out_row_next;
    logic out_free_reg, out_free_next;

    logic [DW-1:0] dim_w, dim_h;
    logic [CW-1:0] in_col, in_row;
    logic in_xfer;
    logic mem_wr_en, mem_wr_data, mem_rd_data;
    logic [AW-1:0] mem_wr_addr, mem_rd_addr;
    nfcs_pkg::gen_ctrl_t gen_ctrl;
    nfcs_pkg::gen_stat_t gen_stat;
    logic [CW-1:0] cand_col, cand_row;

    assign dim_w    = eff_dim(grid_width_reg);
    assign dim_h    = eff_dim(grid_height_reg);
    assign in_col   = clamp_coord(target_col, dim_w);
    assign in_row   = clamp_coord(target_row, dim_h);
    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign mem_rd_addr = cell_addr(cand_col, cand_row);

    nfcs_map_mem #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_map (
        .clk    (clk),
        .wr_en  (mem_wr_en),
        .wr_addr(mem_wr_addr),
        .wr_data(mem_wr_data),
        .rd_en  (gen_stat.cand_valid),
        .rd_addr(mem_rd_addr),
        .rd_data(mem_rd_data)
    );

    nfcs_ring_gen #(
        .MAX_DIM(MAX_DIM),
        .CW     (CW),
        .DW     (DW)
    ) u_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (gen_ctrl),
        .pref_col(pc_reg),
        .pref_row(pr_reg),
        .dim_w   (dim_w),
        .dim_h   (dim_h),
        .stat    (gen_stat),
        .cand_col(cand_col),
        .cand_row(cand_row)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        pc_next        = pc_reg;
        pr_next        = pr_reg;
        res_col_next   = res_col_reg;
        res_row_next   = res_row_reg;
        res_free_next  = res_free_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_free_next  = out_free_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = cell_addr(in_col, in_row);
        mem_wr_data    = blocked_bit;
        gen_ctrl       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = 1'b0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_A)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (command == nfcs_pkg::CMD_WRITE)
                    begin
                        mem_wr_en = 1'b1;
                    end
                    else
                    begin
                        pc_next        = in_col;
                        pr_next        = in_row;
                        gen_ctrl.start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chk_valid_reg && !mem_rd_data)
                begin
                    gen_ctrl.halt = 1'b1;
                    res_col_next  = chk_col_reg;
                    res_row_next  = chk_row_reg;
                    res_free_next = 1'b1;
                    state_next    = ST_FINISH;
                end
                else if (gen_stat.exhausted)
                begin
                    res_col_next  = pc_reg;
                    res_row_next  = pr_reg;
                    res_free_next = 1'b0;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_col_next   = XW'(res_col_reg);
                    out_row_next   = XW'(res_row_reg);
                    out_free_next  = res_free_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            grid_width_reg  <= nfcs_pkg::GRID_DIM_RESET;
            grid_height_reg <= nfcs_pkg::GRID_DIM_RESET;
            chk_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            chk_valid_reg <= gen_stat.cand_valid;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    nfcs_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                    nfcs_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg       <= pc_next;
        pr_reg       <= pr_next;
        chk_col_reg  <= cand_col;
        chk_row_reg  <= cand_row;
        res_col_reg  <= res_col_next;
        res_row_reg  <= res_row_next;
        res_free_reg <= res_free_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_free_reg <= out_free_next;
    end

    assign out_valid  = out_valid_reg;
    assign found_col  = out_col_reg[nfcs_pkg::OUT_COORD_W-1:0];
    assign found_row  = out_row_reg[nfcs_pkg::OUT_COORD_W-1:0];
    assign found_free = out_free_reg;

endmodule

`default_nettype wire

/* hw/rtl/nfcs_checker.sv */
// Port-level checks for the nearest free cell search, attached to the top level by bind.
// Depends on nfcs_pkg and on the port names of nearest_free_cell_search.
`default_nettype none

module nfcs_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_stall,
    input wire logic                                command,
    input wire logic                                out_valid,
    input wire logic                                out_stall,
    input wire logic [nfcs_pkg::OUT_COORD_W-1:0]    found_col,
    input wire logic [nfcs_pkg::OUT_COORD_W-1:0]    found_row,
    input wire logic                                found_free
);

    // A held result keeps its payload until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable({found_col, found_row, found_free}))
        else $error("result payload changed while stalled");

    // A write transfer never produces a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == nfcs_pkg::CMD_WRITE && !out_valid
        |=> !out_valid)
        else $error("result appeared after a write transfer");

    // A query keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && command == nfcs_pkg::CMD_QUERY |=> in_stall)
        else $error("input taken right after a query transfer");

    // A new result is only produced at the end of a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

endmodule

bind nearest_free_cell_search nfcs_checker u_nfcs_checker (.*);

`default_nettype wire
